// ===== design/rts_pkg.sv =====
package rts_pkg;

  localparam int NUM_CLIENTS = 4;
  localparam int OFFSET_W    = 16;
  localparam int DUR_W       = 24;
  localparam int INDEX_W     = 32;
  localparam int PRESCALE_W  = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // request codes
  localparam logic [1:0] REQ_TICK         = 2'd0;
  localparam logic [1:0] REQ_SET_DURATION = 2'd1;
  localparam logic [1:0] REQ_READ_TIME    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_US   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DUR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUR         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUR         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_OFFSETS  = 3'd5;

  localparam logic [DUR_W-1:0]      DEFAULT_DUR_RST = 24'd10000;
  localparam logic [DUR_W-1:0]      MIN_DUR_RST     = 24'd1000;
  localparam logic [DUR_W-1:0]      MAX_DUR_RST     = 24'd100000;
  localparam logic [PRESCALE_W-1:0] CYCLES_RST      = 8'd1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [DUR_W-1:0] duration_us;
  } rts_in_t;

  typedef struct packed {
    logic [NUM_CLIENTS-1:0] client_fire_mask;
    logic                   end_interval;
    logic                   start_interval;
    logic [INDEX_W-1:0]     interval_index;
    logic [DUR_W-1:0]       offset_us;
    logic                   time_valid;
    logic                   duration_error;
  } rts_out_t;

  typedef struct packed {
    logic                                run_enable;
    logic [PRESCALE_W-1:0]               cycles_per_us;
    logic [DUR_W-1:0]                    default_duration_us;
    logic [DUR_W-1:0]                    min_duration_us;
    logic [DUR_W-1:0]                    max_duration_us;
    logic [NUM_CLIENTS*OFFSET_W-1:0]     client_offsets;
  } rts_cfg_t;

endpackage

// ===== design/rts_cfg_regs.sv =====
module rts_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [rts_pkg::CFG_IDX_W-1:0]    wr_index_i,
  input  logic [rts_pkg::CFG_DATA_W-1:0]   wr_data_i,
  output rts_pkg::rts_cfg_t                cfg_o,
  output logic                             stop_o
);

  rts_pkg::rts_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_enable          <= 1'b0;
      cfg_q.cycles_per_us       <= rts_pkg::CYCLES_RST;
      cfg_q.default_duration_us <= rts_pkg::DEFAULT_DUR_RST;
      cfg_q.min_duration_us     <= rts_pkg::MIN_DUR_RST;
      cfg_q.max_duration_us     <= rts_pkg::MAX_DUR_RST;
      cfg_q.client_offsets      <= '0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        rts_pkg::CFG_RUN_ENABLE:     cfg_q.run_enable <= wr_data_i[0];
        rts_pkg::CFG_CYCLES_PER_US:
          cfg_q.cycles_per_us <= wr_data_i[rts_pkg::PRESCALE_W-1:0];
        rts_pkg::CFG_DEFAULT_DUR:
          cfg_q.default_duration_us <= wr_data_i[rts_pkg::DUR_W-1:0];
        rts_pkg::CFG_MIN_DUR:
          cfg_q.min_duration_us <= wr_data_i[rts_pkg::DUR_W-1:0];
        rts_pkg::CFG_MAX_DUR:
          cfg_q.max_duration_us <= wr_data_i[rts_pkg::DUR_W-1:0];
        rts_pkg::CFG_CLIENT_OFFSETS:
          cfg_q.client_offsets <= wr_data_i[rts_pkg::NUM_CLIENTS*rts_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o  = cfg_q;
  // clearing run_enable stops the scheduler at once
  assign stop_o = wr_en_i && (wr_index_i == rts_pkg::CFG_RUN_ENABLE) && !wr_data_i[0];

endmodule

// ===== design/rts_core.sv =====
module rts_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_accept_i,
  input  rts_pkg::rts_in_t   item_i,
  input  rts_pkg::rts_cfg_t  cfg_i,
  input  logic               stop_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output rts_pkg::rts_out_t  res_o
);

  localparam int NC = rts_pkg::NUM_CLIENTS;
  localparam int DW = rts_pkg::DUR_W;
  localparam int OW = rts_pkg::OFFSET_W;

  logic                          s0_valid_q;
  rts_pkg::rts_in_t              s0_q;

  logic                          run_q, run_d;
  logic [rts_pkg::PRESCALE_W-1:0] ps_q, ps_d, ps_inc;
  logic [DW-1:0]                 el_q, el_d;
  logic [DW-1:0]                 act_q, act_d;
  logic [DW-1:0]                 pend_q, pend_d;
  logic [rts_pkg::INDEX_W-1:0]   cnt_q, cnt_d;
  logic [NC-1:0]                 fired_q, fired_d, fired_mid;
  logic [NC-1:0]                 leftover, newly;
  logic                          boundary, check_fire, dur_err;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= item_accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_accept_i) begin
      s0_q <= item_i;
    end
  end

  always_comb begin
    run_d      = run_q;
    ps_d       = ps_q;
    el_d       = el_q;
    act_d      = act_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    fired_mid  = fired_q;
    leftover   = '0;
    boundary   = 1'b0;
    check_fire = 1'b0;
    dur_err    = 1'b0;
    ps_inc     = ps_q + 1'b1;
    newly      = '0;

    case (s0_q.req_type)
      rts_pkg::REQ_TICK: begin
        if (!run_q) begin
          if (cfg_i.run_enable) begin
            // start: first interval begins on this tick
            run_d      = 1'b1;
            act_d      = cfg_i.default_duration_us;
            pend_d     = cfg_i.default_duration_us;
            cnt_d      = cnt_q + 1'b1;
            el_d       = '0;
            ps_d       = '0;
            fired_mid  = '0;
            boundary   = 1'b1;
            check_fire = 1'b1;
          end
        end else begin
          if (ps_inc >= cfg_i.cycles_per_us) begin
            ps_d = '0;
            el_d = el_q + 1'b1;
          end else begin
            ps_d = ps_inc;
          end
          if (el_d >= act_q) begin
            leftover  = ~fired_q;
            cnt_d     = cnt_q + 1'b1;
            el_d      = '0;
            ps_d      = '0;
            act_d     = pend_q;
            fired_mid = '0;
            boundary  = 1'b1;
          end
          check_fire = 1'b1;
        end
      end
      rts_pkg::REQ_SET_DURATION: begin
        if (s0_q.duration_us >= cfg_i.min_duration_us &&
            s0_q.duration_us <= cfg_i.max_duration_us) begin
          pend_d = s0_q.duration_us;
        end else begin
          dur_err = 1'b1;
        end
      end
      default: ;
    endcase

    if (check_fire) begin
      for (int i = 0; i < NC; i++) begin
        if (!fired_mid[i] &&
            {{(DW-OW){1'b0}}, cfg_i.client_offsets[OW*i +: OW]} <= el_d) begin
          newly[i] = 1'b1;
        end
      end
    end
    fired_d = fired_mid | newly;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      ps_q    <= '0;
      el_q    <= '0;
      act_q   <= rts_pkg::DEFAULT_DUR_RST;
      pend_q  <= rts_pkg::DEFAULT_DUR_RST;
      cnt_q   <= '0;
      fired_q <= '1;
    end else if (stop_i) begin
      run_q <= 1'b0;
    end else if (s0_valid_q) begin
      run_q   <= run_d;
      ps_q    <= ps_d;
      el_q    <= el_d;
      act_q   <= act_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      fired_q <= fired_d;
    end
  end

  assign busy_o      = s0_valid_q;
  assign res_valid_o = s0_valid_q;

  always_comb begin
    res_o.client_fire_mask = leftover | newly;
    res_o.end_interval     = boundary;
    res_o.start_interval   = boundary;
    res_o.interval_index   = run_d ? cnt_d : '0;
    res_o.offset_us        = run_d ? el_d : '0;
    res_o.time_valid       = run_d;
    res_o.duration_error   = dur_err;
  end

endmodule

// ===== design/rts_out_fifo.sv =====
module rts_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  rts_pkg::rts_out_t             data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output rts_pkg::rts_out_t             data_o,
  output logic [rts_pkg::FIFO_CW-1:0]   count_o
);

  rts_pkg::rts_out_t               mem_q [rts_pkg::FIFO_DEPTH];
  logic [rts_pkg::FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [rts_pkg::FIFO_CW-1:0]     cnt_q;
  logic                            do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

// ===== design/rti_client_trigger_scheduler.sv =====
// Interval scheduler driven by clock ticks, one request per input transfer.
// Input channel (in_valid_i/in_ready_o, in_data_i): a tick, a request for the
// next interval length, or a time read. Every request gives exactly one result
// on the output channel (out_valid_o/out_ready_i, out_data_o) with the client
// fire mask, interval end/start flags, the current interval index and offset,
// and a duration range error flag.
// Configuration channel (cfg_valid_i/cfg_ready_o): register index and data,
// always ready; write it only while no request is in flight.
// Path: an accepted request is registered in the core's input register; its
// result is then written into the result queue, which drives out_valid_o, and
// the result transfer is taken from the queue.
// Throughput: one request per cycle while in_ready_o is high. A four-entry
// result queue lets input transfers continue while the receiver stalls;
// in_ready_o drops once the queue plus the item in the core would fill it,
// and resumes as results are taken.
// Reset: scheduler stopped, durations 10000 us, prescaler 1, min 1000 us,
// max 100000 us, offsets 0, result queue empty. No clearing pass is needed.
module rti_client_trigger_scheduler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rts_pkg::rts_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rts_pkg::rts_out_t                out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rts_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rts_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  rts_pkg::rts_cfg_t               cfg;
  logic                            stop;
  logic                            in_accept;
  logic                            core_busy;
  logic                            res_valid;
  rts_pkg::rts_out_t               res;
  logic [rts_pkg::FIFO_CW-1:0]     fifo_count;
  logic [rts_pkg::FIFO_CW-1:0]     occupancy;

  assign cfg_ready_o = 1'b1;

  // room must remain for the item still in the core
  assign occupancy  = fifo_count + {{(rts_pkg::FIFO_CW-1){1'b0}}, core_busy};
  assign in_ready_o = (occupancy < rts_pkg::FIFO_CW'(rts_pkg::FIFO_DEPTH));
  assign in_accept  = in_valid_i && in_ready_o;

  rts_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg),
    .stop_o     (stop)
  );

  rts_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_accept_i (in_accept),
    .item_i        (in_data_i),
    .cfg_i         (cfg),
    .stop_i        (stop),
    .busy_o        (core_busy),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  rts_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (out_data_o),
    .count_o (fifo_count)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= rts_pkg::FIFO_CW'(rts_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_accept_reaches_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> core_busy)
    else $error("accepted transfer lost before the core");

  a_boundary_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.end_interval == out_data_o.start_interval))
    else $error("interval end and start disagree");

  a_stopped_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.time_valid) |->
      (out_data_o.interval_index == '0 && out_data_o.offset_us == '0 &&
       out_data_o.client_fire_mask == '0 && !out_data_o.end_interval))
    else $error("activity reported while stopped");

endmodule
